// ===== design/hsvrgb_pkg.sv =====
// Shared constants, types and helpers for the HSV to RGB converter.
package hsvrgb_pkg;

    localparam int FRAC_BITS    = 12;
    localparam int VAL_W        = FRAC_BITS + 1;
    localparam int HUE_W        = 16;
    localparam int IN_W         = 13;
    localparam int CHAN_W       = 13;
    localparam int ONE_FX       = 1 << FRAC_BITS;
    localparam int SECTOR_UNITS = 3840;
    localparam int FULL_TURN    = 6 * SECTOR_UNITS;
    localparam int REM_W        = $clog2(SECTOR_UNITS);
    localparam int NUM_W        = REM_W + FRAC_BITS;

    // Reciprocal of the sector width, rounded up. The extra 24 bits of scale keep the
    // rounding error below one step of the quotient for every possible remainder.
    localparam int FF_SHIFT = FRAC_BITS + 24;
    localparam longint unsigned FF_RECIP =
        ((64'd1 << FF_SHIFT) + SECTOR_UNITS - 1) / SECTOR_UNITS;
    localparam int RECIP_W  = $clog2(FF_RECIP + 1);
    localparam int FFP_W    = NUM_W + RECIP_W;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } sector_t;

    // Clamp an input component to 1.0.
    function automatic logic [VAL_W-1:0] sat_one(input logic [IN_W-1:0] x);
        if (int'(x) > ONE_FX)
        begin
            return VAL_W'(ONE_FX);
        end
        return VAL_W'(x);
    endfunction

endpackage

// ===== design/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: five-stage pipeline, one pixel word per clock cycle unless
// out_ready stalls it. After the sector decode, each stage holds one multiply level
// (divide-by-constant with the v*(1-s) term, two s*f terms, two v*(1-x) terms),
// followed by the sector select into the output register.
// Each stage advances when it is empty or the next one advances, so bubbles collapse.
// rst_n clears the stage valid bits asynchronously; data registers are not reset.
module hsv_to_rgb_converter (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]   hue,
    input  logic [hsvrgb_pkg::IN_W-1:0]    saturation,
    input  logic [hsvrgb_pkg::IN_W-1:0]    brightness,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  red,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  green,
    output logic [hsvrgb_pkg::CHAN_W-1:0]  blue
);
    import hsvrgb_pkg::*;

    localparam logic [VAL_W-1:0]   ONE_V   = VAL_W'(ONE_FX);
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(FF_RECIP);

    // Stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    // Stage 1: clamped inputs, sector and remainder.
    sector_t            s1_sec_reg, s1_sec_next;
    logic [REM_W-1:0]   s1_rem_reg, s1_rem_next;
    logic [VAL_W-1:0]   s1_s_reg, s1_s_next;
    logic [VAL_W-1:0]   s1_v_reg, s1_v_next;
    logic               s1_gray_reg, s1_gray_next;
    logic [HUE_W-1:0]   hue_w;
    logic [HUE_W-1:0]   sec_base;

    // Stage 2: fraction and p.
    sector_t            s2_sec_reg;
    logic [VAL_W-1:0]   s2_s_reg, s2_v_reg;
    logic               s2_gray_reg;
    logic [FRAC_BITS-1:0] s2_ff_reg, s2_ff_next;
    logic [VAL_W-1:0]   s2_p_reg, s2_p_next;
    logic [NUM_W-1:0]   ff_num;
    logic [FFP_W-1:0]   ff_prod;
    logic [2*VAL_W-1:0] p_prod;

    // Stage 3: scaled saturation terms.
    sector_t            s3_sec_reg;
    logic [VAL_W-1:0]   s3_v_reg, s3_p_reg;
    logic               s3_gray_reg;
    logic [VAL_W-1:0]   s3_a_reg, s3_a_next;
    logic [VAL_W-1:0]   s3_b_reg, s3_b_next;
    logic [VAL_W+FRAC_BITS-1:0] a_prod;
    logic [2*VAL_W-1:0] b_prod;

    // Stage 4: q and t.
    sector_t            s4_sec_reg;
    logic [VAL_W-1:0]   s4_v_reg, s4_p_reg;
    logic               s4_gray_reg;
    logic [VAL_W-1:0]   s4_q_reg, s4_q_next;
    logic [VAL_W-1:0]   s4_t_reg, s4_t_next;
    logic [2*VAL_W-1:0] q_prod, t_prod;

    // Stage 5: output register.
    logic [CHAN_W-1:0]  red_reg, red_next;
    logic [CHAN_W-1:0]  green_reg, green_next;
    logic [CHAN_W-1:0]  blue_reg, blue_next;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        s1_s_next    = sat_one(saturation);
        s1_v_next    = sat_one(brightness);
        s1_gray_next = (saturation == '0);
        hue_w        = (int'(hue) >= FULL_TURN) ? '0 : hue;
        if (int'(hue_w) < SECTOR_UNITS)
        begin
            s1_sec_next = SEC_RED_YEL;
            sec_base    = '0;
        end
        else if (int'(hue_w) < 2 * SECTOR_UNITS)
        begin
            s1_sec_next = SEC_YEL_GRN;
            sec_base    = HUE_W'(SECTOR_UNITS);
        end
        else if (int'(hue_w) < 3 * SECTOR_UNITS)
        begin
            s1_sec_next = SEC_GRN_CYN;
            sec_base    = HUE_W'(2 * SECTOR_UNITS);
        end
        else if (int'(hue_w) < 4 * SECTOR_UNITS)
        begin
            s1_sec_next = SEC_CYN_BLU;
            sec_base    = HUE_W'(3 * SECTOR_UNITS);
        end
        else if (int'(hue_w) < 5 * SECTOR_UNITS)
        begin
            s1_sec_next = SEC_BLU_MAG;
            sec_base    = HUE_W'(4 * SECTOR_UNITS);
        end
        else
        begin
            s1_sec_next = SEC_MAG_RED;
            sec_base    = HUE_W'(5 * SECTOR_UNITS);
        end
        s1_rem_next = REM_W'(hue_w - sec_base);
    end

    // Fraction within the sector: (rem << FRAC_BITS) / 3840 by reciprocal multiply, and p.
    always_comb
    begin
        ff_num     = {s1_rem_reg, {FRAC_BITS{1'b0}}};
        ff_prod    = FFP_W'(ff_num) * FFP_W'(RECIP_V);
        s2_ff_next = ff_prod[FF_SHIFT +: FRAC_BITS];
        p_prod     = (2*VAL_W)'(s1_v_reg) * (2*VAL_W)'(ONE_V - s1_s_reg);
        s2_p_next  = p_prod[FRAC_BITS +: VAL_W];
    end

    always_comb
    begin
        a_prod    = (VAL_W+FRAC_BITS)'(s2_s_reg) * (VAL_W+FRAC_BITS)'(s2_ff_reg);
        s3_a_next = a_prod[FRAC_BITS +: VAL_W];
        b_prod    = (2*VAL_W)'(s2_s_reg) * (2*VAL_W)'(ONE_V - VAL_W'(s2_ff_reg));
        s3_b_next = b_prod[FRAC_BITS +: VAL_W];
    end

    always_comb
    begin
        q_prod    = (2*VAL_W)'(s3_v_reg) * (2*VAL_W)'(ONE_V - s3_a_reg);
        s4_q_next = q_prod[FRAC_BITS +: VAL_W];
        t_prod    = (2*VAL_W)'(s3_v_reg) * (2*VAL_W)'(ONE_V - s3_b_reg);
        s4_t_next = t_prod[FRAC_BITS +: VAL_W];
    end

    always_comb
    begin
        if (s4_gray_reg)
        begin
            red_next   = CHAN_W'(s4_v_reg);
            green_next = CHAN_W'(s4_v_reg);
            blue_next  = CHAN_W'(s4_v_reg);
        end
        else
        begin
            case (s4_sec_reg)
                SEC_RED_YEL:
                begin
                    red_next   = CHAN_W'(s4_v_reg);
                    green_next = CHAN_W'(s4_t_reg);
                    blue_next  = CHAN_W'(s4_p_reg);
                end
                SEC_YEL_GRN:
                begin
                    red_next   = CHAN_W'(s4_q_reg);
                    green_next = CHAN_W'(s4_v_reg);
                    blue_next  = CHAN_W'(s4_p_reg);
                end
                SEC_GRN_CYN:
                begin
                    red_next   = CHAN_W'(s4_p_reg);
                    green_next = CHAN_W'(s4_v_reg);
                    blue_next  = CHAN_W'(s4_t_reg);
                end
                SEC_CYN_BLU:
                begin
                    red_next   = CHAN_W'(s4_p_reg);
                    green_next = CHAN_W'(s4_q_reg);
                    blue_next  = CHAN_W'(s4_v_reg);
                end
                SEC_BLU_MAG:
                begin
                    red_next   = CHAN_W'(s4_t_reg);
                    green_next = CHAN_W'(s4_p_reg);
                    blue_next  = CHAN_W'(s4_v_reg);
                end
                default:
                begin
                    red_next   = CHAN_W'(s4_v_reg);
                    green_next = CHAN_W'(s4_p_reg);
                    blue_next  = CHAN_W'(s4_q_reg);
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_sec_reg  <= s1_sec_next;
            s1_rem_reg  <= s1_rem_next;
            s1_s_reg    <= s1_s_next;
            s1_v_reg    <= s1_v_next;
            s1_gray_reg <= s1_gray_next;
        end
        if (en2)
        begin
            s2_sec_reg  <= s1_sec_reg;
            s2_s_reg    <= s1_s_reg;
            s2_v_reg    <= s1_v_reg;
            s2_gray_reg <= s1_gray_reg;
            s2_ff_reg   <= s2_ff_next;
            s2_p_reg    <= s2_p_next;
        end
        if (en3)
        begin
            s3_sec_reg  <= s2_sec_reg;
            s3_v_reg    <= s2_v_reg;
            s3_p_reg    <= s2_p_reg;
            s3_gray_reg <= s2_gray_reg;
            s3_a_reg    <= s3_a_next;
            s3_b_reg    <= s3_b_next;
        end
        if (en4)
        begin
            s4_sec_reg  <= s3_sec_reg;
            s4_v_reg    <= s3_v_reg;
            s4_p_reg    <= s3_p_reg;
            s4_gray_reg <= s3_gray_reg;
            s4_q_reg    <= s4_q_next;
            s4_t_reg    <= s4_t_next;
        end
        if (en5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = v5_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // The sector remainder always stays inside one sector.
    a_rem_in_sector: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (int'(s1_rem_reg) < SECTOR_UNITS))
        else $error("sector remainder out of range");

    // The reciprocal multiply must never round the fraction up to 1.0.
    a_ff_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (int'(s2_ff_reg) < ONE_FX))
        else $error("sector fraction reached one");

    // A stalled stage two keeps its word until stage three frees up.
    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en3) |=> (v2_reg && $stable(s2_ff_reg) && $stable(s2_p_reg)))
        else $error("stalled stage two lost its word");

    // No channel can exceed the clamped value.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (int'(red_reg) <= ONE_FX && int'(green_reg) <= ONE_FX
                    && int'(blue_reg) <= ONE_FX))
        else $error("output channel above full intensity");

endmodule

// ===== sim/hsv_to_rgb_converter_test.sv =====
// Self-checking testbench for the pipelined HSV to RGB pixel converter.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_test;
    import hsvrgb_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [IN_W-1:0]  saturation;
        logic [IN_W-1:0]  brightness;
    } hsv_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_word_t;

    localparam int RANDOM_WORDS = 2000;
    localparam int CALM_FIRST   = 600;
    localparam int CALM_LAST    = 1400;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [HUE_W-1:0] hue = '0;
    logic [IN_W-1:0] saturation = '0;
    logic [IN_W-1:0] brightness = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;

    hsv_word_t pending_words[$];
    rgb_word_t predicted_pixels[$];
    logic in_fire = 1'b0;
    logic hold_output = 1'b0;
    int cycle_count = 0;
    int accepted_words = 0;
    int mismatch_count = 0;

    hsv_to_rgb_converter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Six-sector conversion with every product exact and every shift truncating.
    function automatic rgb_word_t convert_hsv(input hsv_word_t w);
        longint unsigned h;
        longint unsigned s;
        longint unsigned v;
        longint unsigned ff;
        longint unsigned p;
        longint unsigned q;
        longint unsigned t;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        sector_t sec;
        rgb_word_t px;
        s = (w.saturation > ONE_FX) ? ONE_FX : w.saturation;
        v = (w.brightness > ONE_FX) ? ONE_FX : w.brightness;
        if (s == 0)
        begin
            r = v;
            g = v;
            b = v;
        end
        else
        begin
            h = (w.hue >= FULL_TURN) ? 0 : w.hue;
            sec = sector_t'(h / SECTOR_UNITS);
            ff = ((h % SECTOR_UNITS) << FRAC_BITS) / SECTOR_UNITS;
            p = (v * (ONE_FX - s)) >> FRAC_BITS;
            q = (v * (ONE_FX - ((s * ff) >> FRAC_BITS))) >> FRAC_BITS;
            t = (v * (ONE_FX - ((s * (ONE_FX - ff)) >> FRAC_BITS))) >> FRAC_BITS;
            case (sec)
                SEC_RED_YEL: begin r = v; g = t; b = p; end
                SEC_YEL_GRN: begin r = q; g = v; b = p; end
                SEC_GRN_CYN: begin r = p; g = v; b = t; end
                SEC_CYN_BLU: begin r = p; g = q; b = v; end
                SEC_BLU_MAG: begin r = t; g = p; b = v; end
                default:     begin r = v; g = p; b = q; end
            endcase
        end
        px.red = CHAN_W'(r);
        px.green = CHAN_W'(g);
        px.blue = CHAN_W'(b);
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [IN_W-1:0] random_unit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        if (roll < 16)
            return IN_W'(ONE_FX);
        if (roll < 26)
            return IN_W'($urandom_range(ONE_FX + 1, (1 << IN_W) - 1));
        return IN_W'($urandom_range(0, ONE_FX));
    endfunction

    function automatic logic [HUE_W-1:0] random_hue();
        int roll;
        int edge_sec;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            return HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
        if (roll < 25)
        begin
            // Land right on or next to a sector boundary.
            edge_sec = $urandom_range(0, 6);
            return HUE_W'(edge_sec * SECTOR_UNITS + $urandom_range(0, 2) - 1 +
                          (edge_sec == 0 ? 1 : 0));
        end
        return HUE_W'($urandom_range(0, FULL_TURN - 1));
    endfunction

    function automatic logic sender_rests();
        if (cycle_count >= CALM_FIRST && cycle_count <= CALM_LAST)
            return 1'b0;
        return $urandom_range(0, 99) < 15;
    endfunction

    // Input side: a word stays on the port until the cycle after it was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_words.size() != 0 && !sender_rests())
            begin
                hsv_word_t w;
                w = pending_words.pop_front();
                in_valid <= 1'b1;
                hue <= w.hue;
                saturation <= w.saturation;
                brightness <= w.brightness;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_ready <= !hold_output && !sender_rests();
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            hsv_word_t w;
            w.hue = hue;
            w.saturation = saturation;
            w.brightness = brightness;
            predicted_pixels.push_back(convert_hsv(w));
            accepted_words <= accepted_words + 1;
        end
        if (out_valid && out_ready)
        begin
            rgb_word_t want;
            if (predicted_pixels.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d",
                                          red, green, blue));
            end
            else
            begin
                want = predicted_pixels.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("red %0d, want %0d", red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("green %0d, want %0d", green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue %0d, want %0d", blue, want.blue));
            end
        end
    end

    // Stall the output long enough for the pipeline to fill and push back on the input.
    initial
    begin
        wait (accepted_words >= 1500);
        @(negedge clk);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
    end

    initial
    begin
        int hues[10];
        int units[5];
        hsv_word_t w;
        hues = '{0, 3839, 3840, 7680, 11520, 15360, 19200, 23039, 23040, 65535};
        units = '{0, 1, 2048, 4096, 8191};
        foreach (hues[i])
        begin
            w.hue = HUE_W'(hues[i]);
            w.saturation = IN_W'(ONE_FX);
            w.brightness = IN_W'(ONE_FX);
            pending_words.push_back(w);
        end
        foreach (units[i])
        begin
            w.hue = HUE_W'(1920 + i * SECTOR_UNITS);
            w.saturation = IN_W'(units[i]);
            w.brightness = IN_W'(units[4 - i]);
            pending_words.push_back(w);
        end
        // Gray: zero saturation with out-of-range hue and over-range value.
        w.hue = '1;
        w.saturation = '0;
        w.brightness = '1;
        pending_words.push_back(w);
        w.hue = HUE_W'(5000);
        w.saturation = IN_W'(ONE_FX + 1);
        w.brightness = IN_W'(3000);
        pending_words.push_back(w);
        w.hue = HUE_W'(21000);
        w.saturation = '1;
        w.brightness = IN_W'(ONE_FX + 1);
        pending_words.push_back(w);
        w.hue = HUE_W'(FULL_TURN - 1);
        w.saturation = IN_W'(1);
        w.brightness = IN_W'(1);
        pending_words.push_back(w);
        repeat (RANDOM_WORDS)
        begin
            w.hue = random_hue();
            w.saturation = random_unit();
            w.brightness = random_unit();
            pending_words.push_back(w);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do @(posedge clk); while (pending_words.size() != 0 || in_valid);
        do @(posedge clk); while (predicted_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
